// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and disabled while
// rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID controller package
// Types, widths and register codes shared by the clamped PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ErrW   = DataW + 1;
  localparam int unsigned DerrW  = DataW + 2;
  localparam int unsigned PprodW = DataW + ErrW;
  localparam int unsigned DprodW = DataW + DerrW;
  localparam int unsigned IntW   = 25;
  localparam int unsigned FracW  = 8;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic {
    OP_COMPUTE = 1'b0,
    OP_CLEAR   = 1'b1
  } op_e;

  localparam logic [CfgIdxW-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INT_LIMIT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_UPPER = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DRIVE_LOWER = 3'd5;

  localparam logic signed [DataW-1:0] DriveUpperReset = 16'sh7FFF;
  localparam logic signed [DataW-1:0] DriveLowerReset = 16'sh8000;

  typedef struct packed {
    logic signed [DataW-1:0] gain_p;
    logic signed [DataW-1:0] gain_i;
    logic signed [DataW-1:0] gain_d;
    logic        [DataW-1:0] integral_limit;
    logic signed [DataW-1:0] drive_upper;
    logic signed [DataW-1:0] drive_lower;
  } cfg_t;

  // Products of one transaction, handed from the front to the back stage.
  typedef struct packed {
    logic                     valid;
    op_e                      op;
    logic signed [PprodW-1:0] p_prod;
    logic signed [PprodW-1:0] i_prod;
    logic signed [DprodW-1:0] d_prod;
  } prod_t;

endpackage

`default_nettype wire

// ===== design/pidc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// PID configuration registers
// Write-only register file for gains and limits.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pidc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pidc_pkg::DataW-1:0]     cfg_data_i,
  output pidc_pkg::cfg_t                      cfg_o
);
  import pidc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GAIN_P:      cfg_d.gain_p         = cfg_data_i;
        REG_GAIN_I:      cfg_d.gain_i         = cfg_data_i;
        REG_GAIN_D:      cfg_d.gain_d         = cfg_data_i;
        REG_INT_LIMIT:   cfg_d.integral_limit = cfg_data_i;
        REG_DRIVE_UPPER: cfg_d.drive_upper    = cfg_data_i;
        REG_DRIVE_LOWER: cfg_d.drive_lower    = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.integral_limit <= '0;
      cfg_q.drive_upper    <= DriveUpperReset;
      cfg_q.drive_lower    <= DriveLowerReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/pidc_front.sv =====
// ----------------------------------------------------------------------------
// PID front stage
// Input register, error and derivative difference, and the three gain
// products, registered for the back stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pidc_pkg::cfg_t                    cfg_i,
  input  wire logic                              advance_i,
  input  wire logic                              in_valid_i,
  input  wire logic                              operation_i,
  input  wire logic signed [pidc_pkg::DataW-1:0] target_value_i,
  input  wire logic signed [pidc_pkg::DataW-1:0] measured_value_i,
  output pidc_pkg::prod_t                        prod_o
);
  import pidc_pkg::*;

  logic                    in_valid_q;
  op_e                     op_q;
  logic signed [DataW-1:0] target_q;
  logic signed [DataW-1:0] measured_q;
  logic signed [ErrW-1:0]  prev_err_q, prev_err_d;
  logic signed [ErrW-1:0]  err;
  logic signed [DerrW-1:0] derr;
  prod_t                   prod_q, prod_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance_i) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && in_valid_i) begin
      op_q       <= op_e'(operation_i);
      target_q   <= target_value_i;
      measured_q <= measured_value_i;
    end
  end

  always_comb begin
    err  = ErrW'(target_q) - ErrW'(measured_q);
    derr = DerrW'(err) - DerrW'(prev_err_q);

    prod_d.valid  = in_valid_q;
    prod_d.op     = op_q;
    prod_d.p_prod = $signed(cfg_i.gain_p) * err;
    prod_d.i_prod = $signed(cfg_i.gain_i) * err;
    prod_d.d_prod = $signed(cfg_i.gain_d) * derr;

    prev_err_d = prev_err_q;
    if (advance_i && in_valid_q) begin
      prev_err_d = (op_q == OP_CLEAR) ? '0 : err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      prod_q     <= '0;
    end else begin
      prev_err_q <= prev_err_d;
      if (advance_i) begin
        prod_q <= prod_d;
      end
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== design/pidc_back.sv =====
// ----------------------------------------------------------------------------
// PID back stage
// Integral update and clamp, sum of the three terms, truncation toward zero,
// drive limits and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pidc_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pidc_pkg::cfg_t                     cfg_i,
  input  wire logic                               advance_i,
  input  wire pidc_pkg::prod_t                    prod_i,
  output logic                                    drive_valid_o,
  output logic signed [pidc_pkg::DataW-1:0]       drive_value_o
);
  import pidc_pkg::*;

  localparam int unsigned SumW  = PprodW + 1;
  localparam int unsigned AccW  = DprodW + 1;
  localparam int unsigned WholeW = AccW - FracW;

  logic signed [IntW-1:0]   integral_q, integral_d;
  logic signed [IntW-1:0]   int_new;
  logic signed [IntW-1:0]   lim;
  logic signed [SumW-1:0]   isum;
  logic signed [SumW-1:0]   lim_w;
  logic signed [AccW-1:0]   acc;
  logic signed [AccW-1:0]   acc_adj;
  logic signed [WholeW-1:0] whole;
  logic signed [WholeW-1:0] upper_w, lower_w;
  logic signed [DataW-1:0]  drive_d;
  logic signed [DataW-1:0]  drive_q;
  logic                     valid_q;

  always_comb begin
    lim   = $signed({1'b0, cfg_i.integral_limit, {FracW{1'b0}}});
    lim_w = SumW'(lim);
    isum  = SumW'(integral_q) + SumW'(prod_i.i_prod);

    // Clamp the integral to the symmetric limit; the sum never wraps.
    int_new = IntW'(isum);
    if (isum < 0) begin
      if (isum < -lim_w) begin
        int_new = -lim;
      end
    end else if (isum > lim_w) begin
      int_new = lim;
    end

    acc = AccW'(prod_i.p_prod) + AccW'(int_new) + AccW'(prod_i.d_prod);

    // Truncate toward zero: bias negative values before the arithmetic shift.
    acc_adj = acc + ((acc < 0) ? AccW'(255) : AccW'(0));
    whole   = acc_adj[AccW-1:FracW];

    upper_w = WholeW'(cfg_i.drive_upper);
    lower_w = WholeW'(cfg_i.drive_lower);
    if (whole > upper_w) begin
      drive_d = cfg_i.drive_upper;
    end else if (whole < lower_w) begin
      drive_d = cfg_i.drive_lower;
    end else begin
      drive_d = whole[DataW-1:0];
    end

    integral_d = integral_q;
    if (advance_i && prod_i.valid) begin
      if (prod_i.op == OP_CLEAR) begin
        integral_d = '0;
        drive_d    = '0;
      end else begin
        integral_d = int_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      integral_q <= integral_d;
      if (advance_i) begin
        valid_q <= prod_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && prod_i.valid) begin
      drive_q <= drive_d;
    end
  end

  assign drive_valid_o = valid_q;
  assign drive_value_o = drive_q;

  `ASSERT_NXT(a_integral_bounded, advance_i && prod_i.valid && prod_i.op == OP_COMPUTE, (integral_q <= lim) && (integral_q >= -lim), "integral left its limit")
  `ASSERT_NXT(a_clear_gives_zero, advance_i && prod_i.valid && prod_i.op == OP_CLEAR, (drive_q == '0) && (integral_q == '0), "clear did not zero output and integral")
  `ASSERT_NXT(a_drive_in_limits, advance_i && prod_i.valid && prod_i.op == OP_COMPUTE && cfg_i.drive_upper >= cfg_i.drive_lower, (drive_q <= cfg_i.drive_upper) && (drive_q >= cfg_i.drive_lower), "drive outside its limits")

endmodule

`default_nettype wire

// ===== design/pid_controller_clamped_core.sv =====
// ----------------------------------------------------------------------------
// Clamped positional PID controller core
// One control step per input transaction with a clamped integral term.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries an operation (compute or clear), a setpoint and a
// measurement; the output channel returns one drive value per transaction.
// Both channels use valid and stall: a transaction completes at a clock edge
// where valid is high and stall is low.
// A compute step forms the error, adds gain_i times the error to the stored
// integral (clamped to plus or minus integral_limit), sums the P, I and D
// terms, truncates toward zero and applies the upper limit, then the lower.
// A clear zeroes the integral and the previous error and returns zero.
// A result passes through an input register, a register after the three gain
// multipliers, and the result register before drive_valid_o rises. One
// transaction is accepted every cycle while the output is taken.
// Reset clears the pipeline, the integral and the previous error, and sets
// the gains to zero and the drive limits to the full 16-bit range.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o rises, so no result is lost. Configuration is written through a
// plain write port and is meant to change only while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pid_controller_clamped_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pidc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [pidc_pkg::DataW-1:0]          cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                operation_i,
  input  wire logic signed [pidc_pkg::DataW-1:0]   target_value_i,
  input  wire logic signed [pidc_pkg::DataW-1:0]   measured_value_i,
  output logic                                     drive_valid_o,
  input  wire logic                                drive_stall_i,
  output logic signed [pidc_pkg::DataW-1:0]        drive_value_o
);
  import pidc_pkg::*;

  cfg_t  cfg;
  prod_t prod;
  logic  advance;

  // The pipeline moves as a whole unless a finished result is being held.
  assign advance    = !drive_valid_o || !drive_stall_i;
  assign in_stall_o = !advance;

  pidc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pidc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .advance_i        (advance),
    .in_valid_i       (in_valid_i),
    .operation_i      (operation_i),
    .target_value_i   (target_value_i),
    .measured_value_i (measured_value_i),
    .prod_o           (prod)
  );

  pidc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .advance_i     (advance),
    .prod_i        (prod),
    .drive_valid_o (drive_valid_o),
    .drive_value_o (drive_value_o)
  );

  `ASSERT_IMP(a_stall_only_when_full, in_stall_o, drive_valid_o && drive_stall_i, "input stalled without a held result")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Clamped PID controller core testbench
// Drives compute and clear steps through the valid/stall channels and compares
// every drive value against a typed-in value or an internal fixed-point model.
// A short table of directed steps goes first. Random phases follow, each with
// its own register setting and idling mode, and one phase holds off the output.
// ----------------------------------------------------------------------------
module tb_top;
  import pidc_pkg::*;

  // Register indexes that the core does not implement; writes must be ignored.
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

  localparam int CycleLimit   = 300000;
  localparam int DrainCycles  = 8;
  localparam int PhaseItems   = 200;
  localparam int RandomPhases = 8;
  localparam int DirRows      = 25;

  // One directed step. Where has_drive is set, the expected drive value is
  // typed in; otherwise the controller model supplies it.
  typedef struct {
    int                      setting;
    op_e                     op;
    logic signed [DataW-1:0] target;
    logic signed [DataW-1:0] measured;
    bit                      has_drive;
    logic signed [DataW-1:0] drive;
  } step_row_t;

  // Settings used by the directed table, in register order:
  // gain_p, gain_i, gain_d, integral_limit, drive_upper, drive_lower.
  cfg_t dir_settings [7] = '{
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 16'sh7FFF, 16'sh8000},  // as after reset
    '{16'sh0100, 16'sh0000, 16'sh0000, 16'h0000, 16'sh7FFF, 16'sh8000},  // unity P gain
    '{16'sh0000, 16'sh7FFF, 16'sh0000, 16'h0064, 16'sh7FFF, 16'sh8000},  // integral clamp
    '{16'sh0100, 16'sh0000, 16'sh0000, 16'h0000, -16'sd100, 16'sd100},   // crossed limits
    '{16'sh0080, 16'sh0000, 16'sh0000, 16'h0000, 16'sh7FFF, 16'sh8000},  // half P gain
    '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'hFFFF, 16'sh7FFF, 16'sh8000},  // extreme gains
    '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'sh0000, 16'sh0000}   // output pinned
  };

  step_row_t dir_table [DirRows] = '{
    // Gains are zero after reset, so every step gives zero.
    '{0, OP_COMPUTE, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh0000},
    '{0, OP_COMPUTE, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh0000},
    '{0, OP_CLEAR,   16'sh1234, 16'shABCD, 1'b1, 16'sh0000},
    // Unity P gain: the widest errors saturate at the output limits.
    '{1, OP_COMPUTE, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF},
    '{1, OP_COMPUTE, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000},
    '{1, OP_COMPUTE, 16'sd100,  16'sd40,   1'b1, 16'sd60},
    '{1, OP_CLEAR,   16'sh7FFF, 16'sh7FFF, 1'b1, 16'sh0000},
    // Integral overflow: a huge I product is clamped to the integral limit.
    '{2, OP_COMPUTE, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd100},
    '{2, OP_COMPUTE, 16'sh8000, 16'sh7FFF, 1'b1, -16'sd100},
    '{2, OP_COMPUTE, 16'sh0000, 16'sh0000, 1'b1, -16'sd100},
    '{2, OP_CLEAR,   16'sh0000, 16'sh0000, 1'b1, 16'sh0000},
    '{2, OP_COMPUTE, 16'sh0000, 16'sh0000, 1'b1, 16'sh0000},
    // Crossed limits: the upper limit wins whenever it applies.
    '{3, OP_COMPUTE, 16'sd50,   16'sd0,    1'b1, -16'sd100},
    '{3, OP_COMPUTE, -16'sd200, 16'sd0,    1'b1, 16'sd100},
    '{3, OP_COMPUTE, 16'sd0,    16'sd0,    1'b1, -16'sd100},
    // Truncation goes toward zero for negative sums too.
    '{4, OP_COMPUTE, 16'sd0,    16'sd3,    1'b1, -16'sd1},
    '{4, OP_COMPUTE, 16'sd3,    16'sd0,    1'b1, 16'sd1},
    '{4, OP_COMPUTE, 16'sd1,    16'sd0,    1'b1, 16'sd0},
    '{4, OP_COMPUTE, 16'sd0,    16'sd1,    1'b1, 16'sd0},
    // Extreme gains and the widest integral limit, checked by the model.
    '{5, OP_COMPUTE, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000},
    '{5, OP_COMPUTE, 16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000},
    '{5, OP_CLEAR,   16'sh8000, 16'sh8000, 1'b1, 16'sh0000},
    '{5, OP_COMPUTE, 16'sd1234, -16'sd4321, 1'b0, 16'sh0000},
    // Both limits at zero pin the output whatever the gains.
    '{6, OP_COMPUTE, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh0000},
    '{6, OP_COMPUTE, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh0000}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [DataW-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    operation_i;
  logic signed [DataW-1:0] target_value_i;
  logic signed [DataW-1:0] measured_value_i;
  logic                    drive_valid_o;
  logic                    drive_stall_i;
  logic signed [DataW-1:0] drive_value_o;

  // Controller model state and its copy of the registers.
  cfg_t    ctl_cfg;
  longint  integral_q8;
  longint  last_error;

  logic signed [DataW-1:0] expected_drive_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_request;
  int error_count;
  int steps_sent;
  int clears_sent;
  int drives_checked;
  int settings_used;
  int input_stall_cycles;
  int cycle_count;

  pid_controller_clamped_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .target_value_i   (target_value_i),
    .measured_value_i (measured_value_i),
    .drive_valid_o    (drive_valid_o),
    .drive_stall_i    (drive_stall_i),
    .drive_value_o    (drive_value_o)
  );

  always #5 clk_i = ~clk_i;

  // Register write as seen by the model. Unimplemented indexes fall through.
  function automatic void apply_register(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    case (idx)
      REG_GAIN_P:      ctl_cfg.gain_p = data;
      REG_GAIN_I:      ctl_cfg.gain_i = data;
      REG_GAIN_D:      ctl_cfg.gain_d = data;
      REG_INT_LIMIT:   ctl_cfg.integral_limit = data;
      REG_DRIVE_UPPER: ctl_cfg.drive_upper = data;
      REG_DRIVE_LOWER: ctl_cfg.drive_lower = data;
      default: ;
    endcase
  endfunction

  // One control step of the model. The integral and all products carry 8
  // fraction bits and are summed exactly at 64 bits before truncation.
  function automatic logic signed [DataW-1:0] step_controller(op_e op,
                                                              logic signed [DataW-1:0] tgt,
                                                              logic signed [DataW-1:0] meas);
    longint err;
    longint bound;
    longint acc;
    longint drv;
    if (op == OP_CLEAR) begin
      integral_q8 = 0;
      last_error  = 0;
      return '0;
    end
    err   = longint'(tgt) - longint'(meas);
    bound = longint'(ctl_cfg.integral_limit) * 256;
    integral_q8 += longint'($signed(ctl_cfg.gain_i)) * err;
    if (integral_q8 < -bound) begin
      integral_q8 = -bound;
    end else if (integral_q8 > bound) begin
      integral_q8 = bound;
    end
    acc = longint'($signed(ctl_cfg.gain_p)) * err + integral_q8
        + longint'($signed(ctl_cfg.gain_d)) * (err - last_error);
    drv = (acc < 0) ? -((-acc) >>> 8) : (acc >>> 8);
    // The upper limit is tested first, so it wins when the limits cross.
    if (drv > longint'($signed(ctl_cfg.drive_upper))) begin
      drv = longint'($signed(ctl_cfg.drive_upper));
    end else if (drv < longint'($signed(ctl_cfg.drive_lower))) begin
      drv = longint'($signed(ctl_cfg.drive_lower));
    end
    last_error = err;
    return drv[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] pick_edge();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_gain(bit extreme);
    if (extreme || $urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return 16'sh0000;
        3: return 16'sh0100;
        default: return 16'shFF00;
      endcase
    end
    // Modest gains keep most results off the output limits.
    return 16'($urandom_range(16'h0600) - 16'h0300);
  endfunction

  function automatic cfg_t random_setting(bit extreme);
    cfg_t                    s;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    s.gain_p = pick_gain(extreme);
    s.gain_i = pick_gain(extreme);
    s.gain_d = pick_gain(extreme);
    if (extreme) begin
      s.integral_limit = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end else begin
      s.integral_limit = 16'($urandom_range(4000));
    end
    a = 16'($urandom_range(16'hFFFF));
    b = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(3))
      0: begin
        s.drive_upper = DriveUpperReset;
        s.drive_lower = DriveLowerReset;
      end
      1: begin
        // Ordered window.
        s.drive_upper = (a > b) ? a : b;
        s.drive_lower = (a > b) ? b : a;
      end
      2: begin
        // Crossed window.
        s.drive_upper = (a > b) ? b : a;
        s.drive_lower = (a > b) ? a : b;
      end
      default: begin
        s.drive_upper = a;
        s.drive_lower = b;
      end
    endcase
    return s;
  endfunction

  // Inputs change on the falling edge; the register is written at the next
  // rising edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    apply_register(idx, data);
  endtask

  // Writes every register, plus junk to the unimplemented indexes.
  task automatic write_setting(cfg_t s);
    write_reg(REG_GAIN_P, s.gain_p);
    write_reg(REG_GAIN_I, s.gain_i);
    write_reg(REG_GAIN_D, s.gain_d);
    write_reg(REG_INT_LIMIT, s.integral_limit);
    write_reg(REG_DRIVE_UPPER, s.drive_upper);
    write_reg(REG_DRIVE_LOWER, s.drive_lower);
    write_reg(REG_SPARE_A, 16'($urandom_range(16'hFFFF)));
    write_reg(REG_SPARE_B, 16'($urandom_range(16'hFFFF)));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Stops offering steps, waits for every outstanding drive value, and then
  // lets the pipeline settle.
  task automatic finish_outstanding();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offers one step after a random idle gap and holds it until the core takes
  // it. The model runs at the accepting edge, in the order of acceptance.
  task automatic send_step(op_e op, logic signed [DataW-1:0] tgt,
                           logic signed [DataW-1:0] meas, bit has_drive,
                           logic signed [DataW-1:0] drive);
    logic signed [DataW-1:0] predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    target_value_i   <= tgt;
    measured_value_i <= meas;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = step_controller(op, tgt, meas);
    expected_drive_q.push_back(has_drive ? drive : predicted);
    steps_sent++;
    if (op == OP_CLEAR) clears_sent++;
  endtask

  // Random step: mostly control steps with a measurement tracking the target,
  // some fully random and extreme values, and an occasional clear.
  task automatic send_random_step();
    op_e                     op;
    logic signed [DataW-1:0] tgt;
    logic signed [DataW-1:0] meas;
    op  = ($urandom_range(15) == 0) ? OP_CLEAR : OP_COMPUTE;
    tgt = 16'($urandom_range(16'hFFFF));
    case ($urandom_range(9))
      0, 1, 2: meas = 16'($urandom_range(16'hFFFF));
      3: begin
        tgt  = pick_edge();
        meas = pick_edge();
      end
      default: meas = tgt + 16'($urandom_range(400) - 200);
    endcase
    send_step(op, tgt, meas, 1'b0, '0);
  endtask

  // Output side: random stall, or a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left     = 0;
    drive_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_request > 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        drive_stall_i <= 1'b1;
        hold_left--;
      end else begin
        drive_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker: every accepted drive value is compared with the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) input_stall_cycles++;
      if (drive_valid_o && !drive_stall_i) begin
        if (expected_drive_q.size() == 0) begin
          $display("%0t: drive_value %0d arrived with nothing expected",
                   $time, drive_value_o);
          error_count++;
        end else begin
          if (drive_value_o !== expected_drive_q[0]) begin
            $display("%0t: drive_value mismatch, expected %0d, actual %0d",
                     $time, expected_drive_q[0], drive_value_o);
            error_count++;
          end
          void'(expected_drive_q.pop_front());
          drives_checked++;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d drive values outstanding",
             $time, expected_drive_q.size());
    $display("simulation failed");
    $finish;
  end

  // Main sequence.
  initial begin
    int          active_setting;
    int          mode;
    cfg_t        s;
    step_row_t   row;
    int          idle_pct [4];
    int          stall_pct [4];
    idle_pct  = '{0, 82, 0, 14};
    stall_pct = '{0, 0, 82, 14};

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = REG_GAIN_P;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    operation_i        = OP_COMPUTE;
    target_value_i     = '0;
    measured_value_i   = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_off_request   = 0;
    error_count        = 0;
    steps_sent         = 0;
    clears_sent        = 0;
    drives_checked     = 0;
    settings_used      = 1;
    input_stall_cycles = 0;
    // Model state as after reset.
    ctl_cfg     = dir_settings[0];
    integral_q8 = 0;
    last_error  = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table, starting from the reset setting. A new setting is only
    // written once the core has drained.
    active_setting = 0;
    for (int r = 0; r < DirRows; r++) begin
      row = dir_table[r];
      if (row.setting != active_setting) begin
        finish_outstanding();
        write_setting(dir_settings[row.setting]);
        active_setting = row.setting;
      end
      send_step(row.op, row.target, row.measured, row.has_drive, row.drive);
    end

    // Random phases: each gets a fresh setting and one of the idling modes.
    // Every third phase uses extreme register values.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      finish_outstanding();
      s = random_setting(ph % 3 == 0);
      write_setting(s);
      mode           = ph % 4;
      send_idle_pct  = idle_pct[mode];
      recv_stall_pct = stall_pct[mode];
      for (int n = 0; n < PhaseItems; n++) begin
        // Now and then the sender pauses until every result is back.
        if ($urandom_range(99) == 0) finish_outstanding();
        send_random_step();
      end
    end

    // Back-pressure: the output holds off for a long stretch while steps keep
    // coming with no gaps, so the pipeline fills and stalls its input.
    finish_outstanding();
    write_setting(random_setting(1'b0));
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_request = 300;
    for (int n = 0; n < 60; n++) send_random_step();

    finish_outstanding();

    $display("Covered %0d steps (%0d clears) under %0d register settings.",
             steps_sent, clears_sent, settings_used);
    $display("Checked %0d drive values; input stalled for %0d cycles under load.",
             drives_checked, input_stall_cycles);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pidc_pkg.sv
design/pidc_cfg_regs.sv
design/pidc_front.sv
design/pidc_back.sv
design/pid_controller_clamped_core.sv
tb/sv/tb_top.sv
